FILE: sv/swfs_pkg.sv
// Shared types and constants for the slip weakening friction strength block.
package swfs_pkg;

  localparam int NODE_W    = 10;
  localparam int COEF_W    = 18;
  localparam int Q_W       = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATIC_COEF  = 3'd0,
    CFG_KINETIC_COEF = 3'd1,
    CFG_WEAK_DIST    = 3'd2,
    CFG_RELAX_TIME   = 3'd3,
    CFG_TIME_STEP    = 3'd4,
    CFG_SPACE_DIMS   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                     command;
    logic [NODE_W-1:0]        node_index;
    logic                     in_contact;
    logic                     sticking;
    logic [Q_W-1:0]           slip_amount;
    logic signed [Q_W-1:0]    pressure_x;
    logic signed [Q_W-1:0]    pressure_y;
    logic signed [Q_W-1:0]    pressure_z;
  } in_beat_t;

  typedef struct packed {
    logic [NODE_W-1:0] out_node;
    logic [Q_W-1:0]    pressure_magnitude;
    logic [COEF_W-1:0] coefficient;
    logic [Q_W-1:0]    strength;
    logic              saturated;
  } out_beat_t;

  typedef struct packed {
    logic [COEF_W-1:0] static_coefficient;
    logic [COEF_W-1:0] kinetic_coefficient;
    logic [Q_W-1:0]    weakening_distance;
    logic [Q_W-1:0]    relax_time;
    logic [Q_W-1:0]    time_step;
    logic [1:0]        space_dims;
  } cfg_t;

  // Beat handed from the norm and coefficient pipeline to the strength pipeline.
  typedef struct packed {
    logic              command;
    logic [NODE_W-1:0] node;
    logic              contact;
    logic [Q_W-1:0]    norm;
    logic [COEF_W-1:0] mu;
  } fb_t;

endpackage

FILE: sv/swfs_front.sv
// Pipeline for the pressure norm (square root) and the friction coefficient (division).
module swfs_front import swfs_pkg::*; #(
  parameter int MAX_DIMS = 3
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     valid_i,
  input  in_beat_t beat_i,
  output logic     ready_o,
  output logic     valid_o,
  output fb_t      beat_o,
  input  logic     ready_i
);

  localparam int RootSteps  = 4;
  localparam int RootStages = 8;
  localparam int MuSteps    = 3;
  localparam int MuStages   = 6;
  localparam int NumStages  = RootStages + 2;

  typedef struct packed {
    logic              command;
    logic [NODE_W-1:0] node;
    logic              contact;
    logic              use_div;
    logic              neg;
    logic [COEF_W-1:0] mu_fix;
  } tag_t;

  typedef struct packed {
    tag_t            tag;
    logic [2:0][63:0] sq;
    logic [49:0]     prod;
  } f0_t;

  typedef struct packed {
    tag_t        tag;
    logic [63:0] n;
    logic [33:0] rem;
    logic [31:0] root;
    logic [31:0] drem;
    logic [17:0] xlo;
    logic [17:0] q;
  } it_t;

  // One step of the digit-by-digit square root, optionally with one step of the
  // restoring division for the coefficient.
  function automatic it_t it_step(it_t s, logic do_mu, logic [31:0] dc);
    it_t         r;
    logic [35:0] r2;
    logic [35:0] tr;
    logic [32:0] m2;
    r  = s;
    r2 = {r.rem, r.n[63:62]};
    tr = {2'b00, r.root, 2'b01};
    if (r2 >= tr) begin
      r.rem  = 34'(r2 - tr);
      r.root = {r.root[30:0], 1'b1};
    end else begin
      r.rem  = r2[33:0];
      r.root = {r.root[30:0], 1'b0};
    end
    r.n = {r.n[61:0], 2'b00};
    if (do_mu) begin
      m2 = {r.drem, r.xlo[17]};
      if (m2 >= {1'b0, dc}) begin
        r.drem = 32'(m2 - {1'b0, dc});
        r.q    = {r.q[16:0], 1'b1};
      end else begin
        r.drem = m2[31:0];
        r.q    = {r.q[16:0], 1'b0};
      end
      r.xlo = {r.xlo[16:0], 1'b0};
    end
    return r;
  endfunction

  logic [NumStages-1:0] v_q;
  logic [NumStages:0]   rdy;
  f0_t                  f0_q, f0_d;
  it_t                  f1_q, f1_d;
  it_t                  it_q [RootStages];
  it_t                  it_d [RootStages];
  it_t                  it_in [RootStages];
  logic [31:0]          mag [3];
  logic signed [31:0]   pr [3];
  logic [31:0]          rest;
  logic [COEF_W-1:0]    diff;
  it_t                  last;

  always_comb begin
    rdy[NumStages] = ready_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign ready_o = rdy[0];

  // First stage: magnitudes squared and the interpolation product.
  always_comb begin
    pr[0] = beat_i.pressure_x;
    pr[1] = beat_i.pressure_y;
    pr[2] = beat_i.pressure_z;
    f0_d.tag.command = beat_i.command;
    f0_d.tag.node    = beat_i.node_index;
    f0_d.tag.contact = beat_i.in_contact;
    for (int k = 0; k < 3; k++) begin
      mag[k] = pr[k][31] ? (~pr[k] + 32'd1) : pr[k];
      if ((k < MAX_DIMS) && (2'(k) < cfg_i.space_dims)) begin
        f0_d.sq[k] = 64'(mag[k]) * 64'(mag[k]);
      end else begin
        f0_d.sq[k] = '0;
      end
    end
    rest = cfg_i.weakening_distance - beat_i.slip_amount;
    f0_d.tag.neg = cfg_i.static_coefficient < cfg_i.kinetic_coefficient;
    diff = f0_d.tag.neg ? (cfg_i.kinetic_coefficient - cfg_i.static_coefficient)
                        : (cfg_i.static_coefficient - cfg_i.kinetic_coefficient);
    f0_d.prod = 50'(rest) * 50'(diff);
    priority if (beat_i.sticking) begin
      f0_d.tag.use_div = 1'b0;
      f0_d.tag.mu_fix  = cfg_i.static_coefficient;
    end else if (beat_i.slip_amount >= cfg_i.weakening_distance) begin
      f0_d.tag.use_div = 1'b0;
      f0_d.tag.mu_fix  = cfg_i.kinetic_coefficient;
    end else begin
      f0_d.tag.use_div = 1'b1;
      f0_d.tag.mu_fix  = cfg_i.kinetic_coefficient;
    end
  end

  // Second stage: sum of squares and the starting state of both iterations.
  always_comb begin
    f1_d.tag  = f0_q.tag;
    f1_d.n    = f0_q.sq[0] + f0_q.sq[1] + f0_q.sq[2];
    f1_d.rem  = '0;
    f1_d.root = '0;
    f1_d.drem = f0_q.prod[49:18];
    f1_d.xlo  = f0_q.prod[17:0];
    f1_d.q    = '0;
  end

  always_comb begin
    it_in[0] = f1_q;
    for (int j = 1; j < RootStages; j++) begin
      it_in[j] = it_q[j-1];
    end
    for (int j = 0; j < RootStages; j++) begin
      it_d[j] = it_in[j];
      for (int t = 0; t < RootSteps; t++) begin
        it_d[j] = it_step(it_d[j], (t < MuSteps) && (j < MuStages),
                          cfg_i.weakening_distance);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      f0_q <= f0_d;
    end
    if (rdy[1]) begin
      f1_q <= f1_d;
    end
    for (int j = 0; j < RootStages; j++) begin
      if (rdy[j+2]) begin
        it_q[j] <= it_d[j];
      end
    end
  end

  assign last           = it_q[RootStages-1];
  assign valid_o        = v_q[NumStages-1];
  assign beat_o.command = last.tag.command;
  assign beat_o.node    = last.tag.node;
  assign beat_o.contact = last.tag.contact;
  assign beat_o.norm    = last.tag.contact ? last.root : '0;
  assign beat_o.mu      = !last.tag.use_div ? last.tag.mu_fix :
                          last.tag.neg ? (last.tag.mu_fix - last.q)
                                       : (last.tag.mu_fix + last.q);

endmodule

FILE: sv/swfs_back.sv
// Strength pipeline: target product, per-node store, backward Euler division.
module swfs_back import swfs_pkg::*; #(
  parameter int NODES = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      valid_i,
  input  fb_t       beat_i,
  output logic      ready_o,
  output logic      valid_o,
  output out_beat_t beat_o,
  input  logic      ready_i,
  output logic      busy_o
);

  localparam int AW        = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int DivSteps  = 4;
  localparam int DivStages = 8;
  localparam int NumStages = DivStages + 4;

  typedef struct packed {
    logic              command;
    logic [NODE_W-1:0] node;
    logic              contact;
    logic              in_range;
    logic [Q_W-1:0]    norm;
    logic [COEF_W-1:0] mu;
    logic [Q_W-1:0]    target;
    logic              sat;
  } tg_t;

  typedef struct packed {
    tg_t         tg;
    logic [63:0] a;
    logic [63:0] b;
  } b2_t;

  typedef struct packed {
    tg_t         tg;
    logic [32:0] rem;
    logic [31:0] nlo;
    logic [31:0] q;
  } dv_t;

  function automatic dv_t dv_step(dv_t s, logic [32:0] d);
    dv_t         r;
    logic [33:0] r2;
    r  = s;
    r2 = {r.rem, r.nlo[31]};
    if (r2 >= {1'b0, d}) begin
      r.rem = 33'(r2 - {1'b0, d});
      r.q   = {r.q[30:0], 1'b1};
    end else begin
      r.rem = r2[32:0];
      r.q   = {r.q[30:0], 1'b0};
    end
    r.nlo = {r.nlo[30:0], 1'b0};
    return r;
  endfunction

  logic [NumStages-1:0] v_q;
  logic [NumStages:0]   rdy;
  tg_t                  b0_q, b0_d, b1_q;
  b2_t                  b2_q, b2_d;
  dv_t                  b3_q, b3_d;
  dv_t                  dv_q [DivStages];
  dv_t                  dv_d [DivStages];
  dv_t                  dv_in [DivStages];
  logic [49:0]          tprod;
  logic [31:0]          old;
  logic [64:0]          num;
  logic [32:0]          dsum;
  logic [NODE_W-1:0]    node_at [NumStages];
  logic                 wr_at [NumStages];
  logic                 haz;
  logic                 go1;
  logic [31:0]          mem [NODES];
  logic [31:0]          rd_q;
  logic [AW-1:0]        raddr;
  logic                 wr_en;
  logic [31:0]          next;
  logic                 clr_q;
  logic [AW-1:0]        clr_cnt_q;
  dv_t                  last;

  // Target strength, saturated to 32 bits.
  always_comb begin
    tprod          = 50'(beat_i.mu) * 50'(beat_i.norm);
    b0_d.command   = beat_i.command;
    b0_d.node      = beat_i.node;
    b0_d.contact   = beat_i.contact;
    b0_d.in_range  = {22'd0, beat_i.node} < 32'(NODES);
    b0_d.norm      = beat_i.norm;
    b0_d.mu        = beat_i.mu;
    b0_d.sat       = beat_i.contact && (tprod[49:48] != 2'b00);
    b0_d.target    = (tprod[49:48] != 2'b00) ? '1 : tprod[47:16];
  end

  always_comb begin
    old     = b1_q.in_range ? rd_q : '0;
    b2_d.tg = b1_q;
    b2_d.a  = 64'(old) * 64'(cfg_i.relax_time);
    b2_d.b  = 64'(b1_q.target) * 64'(cfg_i.time_step);
  end

  always_comb begin
    num      = {1'b0, b2_q.a} + {1'b0, b2_q.b};
    b3_d.tg  = b2_q.tg;
    b3_d.rem = num[64:32];
    b3_d.nlo = num[31:0];
    b3_d.q   = '0;
  end

  assign dsum = {1'b0, cfg_i.relax_time} + {1'b0, cfg_i.time_step};

  always_comb begin
    dv_in[0] = b3_q;
    for (int j = 1; j < DivStages; j++) begin
      dv_in[j] = dv_q[j-1];
    end
    for (int j = 0; j < DivStages; j++) begin
      dv_d[j] = dv_in[j];
      for (int t = 0; t < DivSteps; t++) begin
        dv_d[j] = dv_step(dv_d[j], dsum);
      end
    end
  end

  // Nodes still waiting for their write; a newer beat for one of them waits.
  always_comb begin
    node_at[0] = b0_q.node;
    wr_at[0]   = 1'b0;
    node_at[1] = b1_q.node;
    wr_at[1]   = v_q[1] && b1_q.in_range;
    node_at[2] = b2_q.tg.node;
    wr_at[2]   = v_q[2] && b2_q.tg.in_range;
    node_at[3] = b3_q.tg.node;
    wr_at[3]   = v_q[3] && b3_q.tg.in_range;
    for (int j = 0; j < DivStages; j++) begin
      node_at[j+4] = dv_q[j].tg.node;
      wr_at[j+4]   = v_q[j+4] && dv_q[j].tg.in_range;
    end
    haz = 1'b0;
    for (int k = 1; k < NumStages; k++) begin
      haz = haz || (wr_at[k] && (node_at[k] == b0_q.node));
    end
    haz = haz && v_q[0] && b0_q.in_range;
  end

  always_comb begin
    rdy[NumStages] = ready_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    go1    = v_q[0] && rdy[1] && !haz;
    rdy[0] = !v_q[0] || (rdy[1] && !haz);
  end

  assign ready_o = rdy[0];
  assign busy_o  = clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) begin
        v_q[0] <= valid_i;
      end
      if (rdy[1]) begin
        v_q[1] <= go1;
      end
      for (int k = 2; k < NumStages; k++) begin
        if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      b0_q <= b0_d;
    end
    if (go1) begin
      b1_q <= b0_q;
    end
    if (rdy[2]) begin
      b2_q <= b2_d;
    end
    if (rdy[3]) begin
      b3_q <= b3_d;
    end
    for (int j = 0; j < DivStages; j++) begin
      if (rdy[j+4]) begin
        dv_q[j] <= dv_d[j];
      end
    end
  end

  assign last = dv_q[DivStages-1];

  always_comb begin
    priority if (!last.tg.contact) begin
      next = '0;
    end else if (last.tg.command || (cfg_i.relax_time == '0)) begin
      next = last.tg.target;
    end else begin
      next = last.q;
    end
  end

  assign wr_en = v_q[NumStages-1] && rdy[NumStages] && last.tg.in_range;
  assign raddr = go1 ? AW'(b0_q.node) : AW'(b1_q.node);

  // Strength store; the read follows the beat that sits in the read stage.
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (wr_en) begin
      mem[AW'(last.tg.node)] <= next;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      if (clr_cnt_q == AW'(NODES - 1)) begin
        clr_q <= 1'b0;
      end
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign valid_o                   = v_q[NumStages-1];
  assign beat_o.out_node           = last.tg.node;
  assign beat_o.pressure_magnitude = last.tg.norm;
  assign beat_o.coefficient        = last.tg.mu;
  assign beat_o.strength           = next;
  assign beat_o.saturated          = last.tg.sat;

`ifndef SYNTHESIS
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (v_q == '0))
    else $error("Beat in flight while the strength store is being cleared.");

  a_no_twin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[1] && v_q[2] && b1_q.in_range && b2_q.tg.in_range) |->
    (b1_q.node != b2_q.tg.node))
    else $error("Two beats for one node are past the read stage together.");

  a_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !clr_q)
    else $error("Strength write collides with the clearing pass.");
`endif

endmodule

FILE: sv/slip_weakening_friction_strength_top.sv
// Top level of the slip weakening friction strength block.
// Each input beat carries one contact node: flags, slip and pressure components.
// The block returns one result beat per input beat, in order, with the pressure
// norm, the friction coefficient and the node's new strength.
// Configuration registers are written through cfg_we_i / cfg_idx_i / cfg_data_i
// while no beat is in flight; they take effect for the next beats.
// An accepted input beat reaches the output register through ten stages that
// compute the norm and coefficient and twelve stages that compute the target,
// read the node store and run the backward Euler division.
// Throughput is one beat per cycle unless the receiver stalls, the store is
// being cleared or a store hazard holds a beat. A beat whose node still has an
// older beat between the store read and its write-back waits at the read stage;
// different nodes stream without gaps. After reset the node store is cleared one
// entry per cycle, and in_stall_o stays high until that pass is done.
// When the receiver stalls, the output register holds its beat and the
// pipeline keeps filling its empty stages, so input is still taken until
// every stage holds a beat.
module slip_weakening_friction_strength_top import swfs_pkg::*; #(
  parameter int NODES    = 1024,
  parameter int MAX_DIMS = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_beat_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_beat_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cfg_t      cfg_q;
  logic      busy;
  logic      front_ready;
  logic      front_valid;
  fb_t       front_beat;
  logic      back_ready;
  logic      back_valid;
  out_beat_t back_beat;
  logic      out_ready;
  logic      out_valid_q;
  out_beat_t out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.static_coefficient  <= '0;
      cfg_q.kinetic_coefficient <= '0;
      cfg_q.weakening_distance  <= '0;
      cfg_q.relax_time          <= '0;
      cfg_q.time_step           <= '0;
      cfg_q.space_dims          <= 2'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STATIC_COEF:  cfg_q.static_coefficient  <= cfg_data_i[COEF_W-1:0];
        CFG_KINETIC_COEF: cfg_q.kinetic_coefficient <= cfg_data_i[COEF_W-1:0];
        CFG_WEAK_DIST:    cfg_q.weakening_distance  <= cfg_data_i;
        CFG_RELAX_TIME:   cfg_q.relax_time          <= cfg_data_i;
        CFG_TIME_STEP:    cfg_q.time_step           <= cfg_data_i;
        CFG_SPACE_DIMS:   cfg_q.space_dims          <= cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  // No beat is taken while the store clearing pass runs.
  assign in_stall_o = busy || !front_ready;

  swfs_front #(
    .MAX_DIMS (MAX_DIMS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i && !busy),
    .beat_i  (in_data_i),
    .ready_o (front_ready),
    .valid_o (front_valid),
    .beat_o  (front_beat),
    .ready_i (back_ready)
  );

  swfs_back #(
    .NODES (NODES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (front_valid),
    .beat_i  (front_beat),
    .ready_o (back_ready),
    .valid_o (back_valid),
    .beat_o  (back_beat),
    .ready_i (out_ready),
    .busy_o  (busy)
  );

  // Output register: it is refilled whenever it is empty or being taken.
  assign out_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= back_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && back_valid) begin
      out_q <= back_beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: tb/tb_slip_weakening_friction_strength_top.sv
// Self-checking testbench for the slip weakening friction strength block.
module tb_slip_weakening_friction_strength_top;
  import swfs_pkg::*;

  localparam int NODE_CNT  = 1024;
  localparam int RAND_BEATS = 550;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  in_beat_t         in_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_beat_t        out_data_o;
  logic             cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  always #1 clk_i = ~clk_i;

  slip_weakening_friction_strength_top #(.NODES(NODE_CNT), .MAX_DIMS(3)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Shadow copy of the configuration and of the per-node strength store.
  cfg_t        shadow_cfg;
  logic [31:0] node_strength [NODE_CNT];

  out_beat_t   pending_results[$];
  int          err_cnt = 0;
  bit          quiet_tail = 1'b0;

  function automatic logic [31:0] mag32(logic [31:0] raw);
    return raw[31] ? (~raw + 32'd1) : raw;
  endfunction

  function automatic logic [31:0] floor_sqrt(logic [65:0] n);
    logic [65:0] res;
    logic [65:0] bitv;
    res = '0;
    bitv = 66'd1 << 64;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  // Computes the result of one node beat and updates the strength shadow.
  function automatic out_beat_t friction_update(in_beat_t b);
    out_beat_t   r;
    logic [65:0] sumsq;
    logic [31:0] m;
    logic [63:0] rest;
    logic [63:0] diff;
    logic [63:0] mu;
    logic [63:0] tgt;
    logic [95:0] num;
    logic [32:0] den;
    logic [31:0] prior;
    int          dims;
    dims = (shadow_cfg.space_dims > 3) ? 3 : shadow_cfg.space_dims;
    sumsq = '0;
    if (dims > 0) begin m = mag32(b.pressure_x); sumsq += 66'(m) * 66'(m); end
    if (dims > 1) begin m = mag32(b.pressure_y); sumsq += 66'(m) * 66'(m); end
    if (dims > 2) begin m = mag32(b.pressure_z); sumsq += 66'(m) * 66'(m); end
    r = '0;
    r.out_node = b.node_index;
    r.pressure_magnitude = b.in_contact ? floor_sqrt(sumsq) : 32'd0;
    if (b.sticking) begin
      mu = 64'(shadow_cfg.static_coefficient);
    end else if (b.slip_amount >= shadow_cfg.weakening_distance) begin
      mu = 64'(shadow_cfg.kinetic_coefficient);
    end else begin
      rest = 64'(shadow_cfg.weakening_distance - b.slip_amount);
      if (shadow_cfg.static_coefficient >= shadow_cfg.kinetic_coefficient) begin
        diff = 64'(shadow_cfg.static_coefficient - shadow_cfg.kinetic_coefficient);
        mu = 64'(shadow_cfg.kinetic_coefficient)
             + rest * diff / 64'(shadow_cfg.weakening_distance);
      end else begin
        diff = 64'(shadow_cfg.kinetic_coefficient - shadow_cfg.static_coefficient);
        mu = 64'(shadow_cfg.kinetic_coefficient)
             - rest * diff / 64'(shadow_cfg.weakening_distance);
      end
    end
    r.coefficient = mu[17:0];
    prior = node_strength[b.node_index];
    if (!b.in_contact) begin
      r.strength = '0;
    end else begin
      tgt = (mu * 64'(r.pressure_magnitude)) >> 16;
      if (tgt > 64'hFFFF_FFFF) begin
        tgt = 64'hFFFF_FFFF;
        r.saturated = 1'b1;
      end
      if (b.command || shadow_cfg.relax_time == 0) begin
        r.strength = tgt[31:0];
      end else begin
        num = 96'(prior) * 96'(shadow_cfg.relax_time)
              + 96'(tgt) * 96'(shadow_cfg.time_step);
        den = 33'(shadow_cfg.relax_time) + 33'(shadow_cfg.time_step);
        num = num / 96'(den);
        r.strength = num[31:0];
      end
    end
    node_strength[b.node_index] = r.strength;
    return r;
  endfunction

  // Random receiver stall bursts, switched off for the final stretch.
  int recv_gap = 0;
  always @(posedge clk_i) begin
    if (quiet_tail) begin
      out_stall_i <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      recv_gap <= $urandom_range(1, 14) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Result checker: every accepted beat is compared with the oldest prediction.
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_data_o);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (want.out_node !== out_data_o.out_node) begin
          $display("%0t: out_node exp %h got %h", $time, want.out_node,
                   out_data_o.out_node);
          err_cnt++;
        end
        if (want.pressure_magnitude !== out_data_o.pressure_magnitude) begin
          $display("%0t: pressure_magnitude exp %h got %h", $time,
                   want.pressure_magnitude, out_data_o.pressure_magnitude);
          err_cnt++;
        end
        if (want.coefficient !== out_data_o.coefficient) begin
          $display("%0t: coefficient exp %h got %h", $time, want.coefficient,
                   out_data_o.coefficient);
          err_cnt++;
        end
        if (want.strength !== out_data_o.strength) begin
          $display("%0t: strength exp %h got %h", $time, want.strength,
                   out_data_o.strength);
          err_cnt++;
        end
        if (want.saturated !== out_data_o.saturated) begin
          $display("%0t: saturated exp %b got %b", $time, want.saturated,
                   out_data_o.saturated);
          err_cnt++;
        end
      end
    end
  end

  // Writes one register and mirrors it in the shadow configuration.
  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_STATIC_COEF:  shadow_cfg.static_coefficient  = val[17:0];
      CFG_KINETIC_COEF: shadow_cfg.kinetic_coefficient = val[17:0];
      CFG_WEAK_DIST:    shadow_cfg.weakening_distance  = val;
      CFG_RELAX_TIME:   shadow_cfg.relax_time          = val;
      CFG_TIME_STEP:    shadow_cfg.time_step           = val;
      CFG_SPACE_DIMS:   shadow_cfg.space_dims          = val[1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sends one beat, with an optional random gap first, and predicts its result.
  // Keeps valid high across back-to-back beats; it drops low only for a random gap.
  task automatic send_beat(in_beat_t b, bit allow_gap);
    if (allow_gap && !quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(friction_update(b));
  endtask

  // Waits until every predicted beat has come back, then lets the pipeline
  // drain past its latency before the configuration may change.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic in_beat_t random_beat(int node_span);
    in_beat_t b;
    b.command     = 1'($urandom_range(0, 1));
    b.node_index  = 10'($urandom_range(0, node_span));
    b.in_contact  = ($urandom_range(0, 5) != 0);
    b.sticking    = ($urandom_range(0, 3) == 0);
    case ($urandom_range(0, 3))
      0: b.slip_amount = $urandom;
      1: b.slip_amount = shadow_cfg.weakening_distance + $urandom_range(0, 3) - 1;
      default: b.slip_amount = $urandom_range(0, 32'h0004_0000);
    endcase
    b.pressure_x = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0040_0000);
    b.pressure_y = $urandom;
    b.pressure_z = ($urandom_range(0, 1)) ? $urandom : -$urandom_range(0, 32'h0010_0000);
    return b;
  endfunction

  typedef struct {
    in_beat_t  beat;
    bit        has_known;
    out_beat_t known;
  } stim_row_t;

  // Directed rows. Known results are given where they follow directly from
  // the register state; the rest are checked by the predictor only.
  stim_row_t directed[] = '{
    // Reset state: all coefficients zero, so coefficient and strength read zero.
    '{'{1'b0, 10'd0, 1'b1, 1'b0, 32'd0, 32'd3, 32'd4, 32'd0}, 1'b1,
      '{10'd0, 32'd5, 18'd0, 32'd0, 1'b0}},
    '{'{1'b1, 10'd1023, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h8000_0000, 32'h8000_0000}, 1'b1, '{10'd1023, 32'd0, 18'd0, 32'd0, 1'b0}},
    '{'{1'b0, 10'd5, 1'b1, 1'b0, 32'h0001_0000, 32'h7FFF_FFFF,
        32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, '0}
  };

  // Settings walked during the directed phases: static, kinetic, Dc, t_star,
  // dt, dims. Extremes of every register appear.
  logic [31:0] setups [6][6] = '{
    '{32'h0001_8000, 32'h0000_8000, 32'h0002_0000, 32'h0001_0000, 32'h0000_4000, 32'd3},
    '{32'h3FFFF,     32'h3FFFF,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0},
    '{32'h0000_4000, 32'h0003_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'd1},
    '{32'h0000_0000, 32'h3FFFF,     32'h0010_0000, 32'h0002_0000, 32'h0000_0000, 32'd2},
    '{32'h3FFFF,     32'h0000_0000, 32'h0001_0000, 32'h0000_8000, 32'h0001_0000, 32'd3},
    '{32'h0001_0000, 32'h0000_C000, 32'h0000_1000, 32'h0000_0001, 32'hFFFF_FFFF, 32'd3}
  };

  initial begin
    in_beat_t  b;
    out_beat_t got;
    shadow_cfg = '{default: '0, space_dims: 2'd3};
    foreach (node_strength[i]) node_strength[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table at reset settings; known rows are checked twice over.
    foreach (directed[i]) begin
      got = friction_update(directed[i].beat);
      if (directed[i].has_known && got !== directed[i].known) begin
        $display("%0t: table row %0d exp %h got %h", $time, i, directed[i].known, got);
        err_cnt++;
      end
      pending_results.push_back(got);
      in_valid_i <= 1'b1;
      in_data_i  <= directed[i].beat;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
    end
    drain();

    // Each setting gets a few directed edge beats and a slice of random beats.
    for (int s = 0; s < 6; s++) begin
      write_reg(CFG_STATIC_COEF,  setups[s][0]);
      write_reg(CFG_KINETIC_COEF, setups[s][1]);
      write_reg(CFG_WEAK_DIST,    setups[s][2]);
      write_reg(CFG_RELAX_TIME,   setups[s][3]);
      write_reg(CFG_TIME_STEP,    setups[s][4]);
      write_reg(CFG_SPACE_DIMS,   setups[s][5]);
      b = '{1'b0, 10'd7, 1'b1, 1'b0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      send_beat(b, 1'b0);
      b.command = 1'b1; b.sticking = 1'b1;
      send_beat(b, 1'b0);
      b = '{1'b0, 10'd7, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0001_0000, 32'd0, 32'd0};
      send_beat(b, 1'b0);
      // Same node back to back exercises the store hazard stall.
      for (int k = 0; k < RAND_BEATS / 6; k++) begin
        if (s == 5 && k > RAND_BEATS / 6 - 30) quiet_tail = 1'b1;
        send_beat(random_beat(($urandom_range(0, 2) == 0) ? 3 : NODE_CNT - 1), 1'b1);
      end
      drain();
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
